// File: rtl/owdm_pkg.sv
// owdm_pkg: types, constants and the quarter-wave cosine table for the mixer.
// No dependencies.
package owdm_pkg;
  localparam int WheelCount = 4;
  localparam int AngW = 9;
  localparam int CosW = 17;
  localparam int DivW = 32;
  localparam logic [1:0] DirBrake = 2'd0;
  localparam logic [1:0] DirFwd = 2'd1;
  localparam logic [1:0] DirRev = 2'd2;
  localparam logic [1:0] RegW0 = 2'd0;
  localparam logic [1:0] RegW1 = 2'd1;
  localparam logic [1:0] RegW2 = 2'd2;
  localparam logic [1:0] RegW3 = 2'd3;

  typedef struct packed {
    logic [8:0] heading;
    logic signed [7:0] drive_speed;
    logic signed [7:0] turn_correction;
  } cmd_t;

  typedef struct packed {
    logic [7:0] wheel0_duty;
    logic [7:0] wheel1_duty;
    logic [7:0] wheel2_duty;
    logic [7:0] wheel3_duty;
    logic [1:0] wheel0_dir;
    logic [1:0] wheel1_dir;
    logic [1:0] wheel2_dir;
    logic [1:0] wheel3_dir;
  } res_t;

  typedef struct packed {
    logic signed [7:0] speed;
    logic signed [7:0] corr;
    logic [WheelCount-1:0][8:0] ang;
  } job_t;

  function automatic logic [15:0] cos_tab(input logic [6:0] k);
    logic [15:0] r;
    case (k)
      7'd0: r = 16'd32768; 7'd1: r = 16'd32763; 7'd2: r = 16'd32748;
      7'd3: r = 16'd32723; 7'd4: r = 16'd32688; 7'd5: r = 16'd32643;
      7'd6: r = 16'd32588; 7'd7: r = 16'd32524; 7'd8: r = 16'd32449;
      7'd9: r = 16'd32365; 7'd10: r = 16'd32270; 7'd11: r = 16'd32166;
      7'd12: r = 16'd32052; 7'd13: r = 16'd31928; 7'd14: r = 16'd31795;
      7'd15: r = 16'd31651; 7'd16: r = 16'd31499; 7'd17: r = 16'd31336;
      7'd18: r = 16'd31164; 7'd19: r = 16'd30983; 7'd20: r = 16'd30792;
      7'd21: r = 16'd30592; 7'd22: r = 16'd30382; 7'd23: r = 16'd30163;
      7'd24: r = 16'd29935; 7'd25: r = 16'd29698; 7'd26: r = 16'd29452;
      7'd27: r = 16'd29197; 7'd28: r = 16'd28932; 7'd29: r = 16'd28660;
      7'd30: r = 16'd28378; 7'd31: r = 16'd28088; 7'd32: r = 16'd27789;
      7'd33: r = 16'd27482; 7'd34: r = 16'd27166; 7'd35: r = 16'd26842;
      7'd36: r = 16'd26510; 7'd37: r = 16'd26170; 7'd38: r = 16'd25822;
      7'd39: r = 16'd25466; 7'd40: r = 16'd25102; 7'd41: r = 16'd24730;
      7'd42: r = 16'd24351; 7'd43: r = 16'd23965; 7'd44: r = 16'd23571;
      7'd45: r = 16'd23170; 7'd46: r = 16'd22763; 7'd47: r = 16'd22348;
      7'd48: r = 16'd21926; 7'd49: r = 16'd21498; 7'd50: r = 16'd21063;
      7'd51: r = 16'd20622; 7'd52: r = 16'd20174; 7'd53: r = 16'd19720;
      7'd54: r = 16'd19261; 7'd55: r = 16'd18795; 7'd56: r = 16'd18324;
      7'd57: r = 16'd17847; 7'd58: r = 16'd17364; 7'd59: r = 16'd16877;
      7'd60: r = 16'd16384; 7'd61: r = 16'd15886; 7'd62: r = 16'd15384;
      7'd63: r = 16'd14876; 7'd64: r = 16'd14365; 7'd65: r = 16'd13848;
      7'd66: r = 16'd13328; 7'd67: r = 16'd12803; 7'd68: r = 16'd12275;
      7'd69: r = 16'd11743; 7'd70: r = 16'd11207; 7'd71: r = 16'd10668;
      7'd72: r = 16'd10126; 7'd73: r = 16'd9580; 7'd74: r = 16'd9032;
      7'd75: r = 16'd8481; 7'd76: r = 16'd7927; 7'd77: r = 16'd7371;
      7'd78: r = 16'd6813; 7'd79: r = 16'd6252; 7'd80: r = 16'd5690;
      7'd81: r = 16'd5126; 7'd82: r = 16'd4560; 7'd83: r = 16'd3993;
      7'd84: r = 16'd3425; 7'd85: r = 16'd2856; 7'd86: r = 16'd2286;
      7'd87: r = 16'd1715; 7'd88: r = 16'd1144; 7'd89: r = 16'd572;
      default: r = 16'd0;
    endcase
    return r;
  endfunction
endpackage

// File: rtl/owdm_if.sv
// owdm_if: valid/ready channels carrying a cmd_t or a res_t payload.
// Depends on owdm_pkg for payload types.
interface owdm_cmd_if;
  logic valid;
  logic ready;
  owdm_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface owdm_res_if;
  logic valid;
  logic ready;
  owdm_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/owdm_front.sv
// owdm_front: accepts commands, drops repeats, queues jobs with current angles.
// Depends on owdm_pkg, owdm_if.
module owdm_front (
  input  logic clk_i,
  input  logic rst_ni,
  owdm_cmd_if.sink cmd,
  input  logic [3:0][8:0] ang_i,
  output logic job_valid_o,
  output owdm_pkg::job_t job_o,
  input  logic job_ready_i
);
  import owdm_pkg::*;
  logic [8:0] last_h_q;
  logic [7:0] last_s_q, last_c_q;
  job_t q_q [2];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;
  logic acc, rep, push, pop;
  job_t nj;

  assign cmd.ready = (cnt_q != 2'd2);
  assign acc = cmd.valid && cmd.ready;
  assign rep = (cmd.data.heading == last_h_q) && (cmd.data.drive_speed == last_s_q)
    && (cmd.data.turn_correction == last_c_q);
  assign push = acc && !rep;
  assign pop = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = q_q[rp_q];

  always_comb begin
    nj.speed = cmd.data.drive_speed;
    nj.corr = cmd.data.turn_correction;
    for (int i = 0; i < WheelCount; i++) begin
      // cos(a+90-h): angle index kept mod 360 on 11 bits
      logic [10:0] a, b;
      a = {2'b0, ang_i[i]};
      if (a >= 11'd360) a = a - 11'd360;
      b = {2'b0, cmd.data.heading};
      if (b >= 11'd360) b = b - 11'd360;
      a = a + 11'd450 - b;
      if (a >= 11'd360) a = a - 11'd360;
      if (a >= 11'd360) a = a - 11'd360;
      nj.ang[i] = a[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_h_q <= '0; last_s_q <= '0; last_c_q <= '0;
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (acc) begin
        last_h_q <= cmd.data.heading;
        last_s_q <= cmd.data.drive_speed;
        last_c_q <= cmd.data.turn_correction;
      end
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= nj;
  end
endmodule

// File: rtl/owdm_div.sv
// owdm_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on owdm_pkg.
module owdm_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [owdm_pkg::DivW-1:0] num_i,
  input  logic [16:0] den_i,
  output logic done_o,
  output logic [owdm_pkg::DivW-1:0] quo_o
);
  import owdm_pkg::*;
  logic [DivW-1:0] n_q;
  logic [17:0] r_q;
  logic [5:0] k_q;
  logic busy_q;
  logic [17:0] rs;

  assign rs = {r_q[16:0], n_q[DivW-1]};
  assign quo_o = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; k_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; k_q <= 6'(DivW);
      end else if (busy_q) begin
        k_q <= k_q - 6'd1;
        if (k_q == 6'd1) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i; r_q <= '0;
    end else if (busy_q) begin
      if (rs >= {1'b0, den_i}) begin
        r_q <= rs - {1'b0, den_i}; n_q <= {n_q[DivW-2:0], 1'b1};
      end else begin
        r_q <= rs; n_q <= {n_q[DivW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/owdm_back.sv
// owdm_back: sequencer for the two scaling passes and duty conversion.
// Depends on owdm_pkg, owdm_div.
module owdm_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  owdm_pkg::job_t job_i,
  output logic job_ready_o,
  owdm_res_if.source res
);
  import owdm_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SCos = 3'd1, SP1 = 3'd2, SP1W = 3'd3,
    SP2 = 3'd4, SP2W = 3'd5, SOut = 3'd6;
  logic [2:0] st_q;
  logic [1:0] w_q;
  logic signed [17:0] v_q [WheelCount];
  logic [16:0] m_q;
  logic [16:0] m_acc_q;
  logic signed [7:0] s_q, c_q;
  logic [3:0][8:0] a_q;
  logic brake_q;
  logic dstart, ddone;
  logic [DivW-1:0] dnum, dquo;
  logic signed [33:0] prod_q;
  logic signed [17:0] q_s, cosv, p1v;
  logic [8:0] ai;

  assign job_ready_o = (st_q == SIdle) && !res.valid;

  always_comb begin
    ai = a_q[w_q];
    if (ai <= 9'd90) cosv = 18'(cos_tab(ai[6:0]));
    else if (ai <= 9'd180) cosv = -18'(cos_tab(7'(9'd180 - ai)));
    else if (ai <= 9'd270) cosv = -18'(cos_tab(7'(ai - 9'd180)));
    else cosv = 18'(cos_tab(7'(9'd360 - ai)));
  end

  assign dnum = prod_q[33] ? DivW'(-prod_q) : DivW'(prod_q);
  assign q_s = prod_q[33] ? -18'(dquo) : 18'(dquo);
  assign p1v = q_s + (18'(c_q) <<< 8);

  owdm_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(m_q),
    .done_o(ddone), .quo_o(dquo));

  // duty = min(|v|*255/25600, 255): |v|*51 >> 10, then /5 by reciprocal
  function automatic logic [9:0] duty_dir(input logic signed [17:0] v, input logic br);
    logic [16:0] mg;
    logic [22:0] p;
    logic [22:0] t;
    logic [7:0] d;
    logic [1:0] r;
    mg = v[17] ? 17'(-v) : 17'(v);
    p = 23'(mg) * 23'd51;
    t = 23'(p[20:10]) * 23'd3277;
    d = (mg >= 17'd25600) ? 8'd255 : t[21:14];
    r = v[17] ? DirRev : DirFwd;
    if (br || v == '0) begin
      d = '0; r = DirBrake;
    end
    return {d, r};
  endfunction

  function automatic logic [16:0] m_next(input logic [16:0] m, input logic signed [17:0] v);
    logic [16:0] a;
    a = v[17] ? 17'(-v) : 17'(v);
    return (a > m) ? a : m;
  endfunction

  logic [9:0] o0, o1, o2, o3;
  assign o0 = duty_dir(v_q[0], brake_q);
  assign o1 = duty_dir(v_q[1], brake_q);
  assign o2 = duty_dir(v_q[2], brake_q);
  assign o3 = duty_dir(v_q[3], brake_q);

  logic pstart_q;
  assign dstart = pstart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; w_q <= '0; res.valid <= 1'b0; pstart_q <= 1'b0;
    end else begin
      pstart_q <= 1'b0;
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (st_q)
        SIdle: if (job_valid_i && job_ready_o) begin
          w_q <= '0;
          st_q <= (job_i.speed == '0) ? SOut : SCos;
        end
        SCos: begin
          w_q <= w_q + 2'd1;
          if (w_q == 2'd3) begin
            st_q <= SP1;
          end
        end
        SP1, SP2: begin
          if (m_q == '0) st_q <= SOut;
          else begin
            pstart_q <= 1'b1; st_q <= (st_q == SP1) ? SP1W : SP2W;
          end
        end
        SP1W: if (ddone) begin
          w_q <= w_q + 2'd1;
          st_q <= (w_q == 2'd3) ? SP2 : SP1W;
          if (w_q != 2'd3) pstart_q <= 1'b1;
        end
        SP2W: if (ddone) begin
          w_q <= w_q + 2'd1;
          st_q <= (w_q == 2'd3) ? SOut : SP2W;
          if (w_q != 2'd3) pstart_q <= 1'b1;
        end
        SOut: begin
          res.valid <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        s_q <= job_i.speed; c_q <= job_i.corr; a_q <= job_i.ang;
        brake_q <= 1'b0; m_q <= '0;
        for (int i = 0; i < WheelCount; i++) v_q[i] <= 18'(job_i.corr) <<< 8;
      end
      SCos: begin
        v_q[w_q] <= cosv;
        if ((cosv[17] ? 17'(-cosv) : 17'(cosv)) > m_q)
          m_q <= cosv[17] ? 17'(-cosv) : 17'(cosv);
        prod_q <= 34'(cosv) * 34'(s_q) * 34'sd256;
      end
      SP1, SP2: begin
        if (m_q == '0) brake_q <= 1'b1;
        prod_q <= 34'(v_q[w_q]) * 34'(s_q) * 34'sd256;
      end
      SP1W: if (ddone) begin
        v_q[w_q] <= p1v;
        prod_q <= 34'(v_q[2'(w_q + 2'd1)]) * 34'(s_q) * 34'sd256;
        if (w_q == 2'd3) begin
          // second divisor: max |v| over all four pass-one results
          m_q <= m_next(m_acc_q, p1v);
          prod_q <= 34'(v_q[0]) * 34'(s_q) * 34'sd256;
        end
      end
      SP2W: if (ddone) begin
        v_q[w_q] <= q_s;
        prod_q <= 34'(v_q[2'(w_q + 2'd1)]) * 34'(s_q) * 34'sd256;
      end
      SOut: begin
        res.data <= {o0[9:2], o1[9:2], o2[9:2], o3[9:2], o0[1:0], o1[1:0], o2[1:0], o3[1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SCos && w_q == 2'd3) m_acc_q <= '0;
    else if (st_q == SP1W && ddone) m_acc_q <= m_next(m_acc_q, p1v);
  end
endmodule

// File: rtl/omni_wheel_drive_mixer.sv
// omni_wheel_drive_mixer: top level; APB angle registers, front, back.
// Depends on owdm_pkg, owdm_if, owdm_front, owdm_back.
//
// Usage: commands enter on cmd (heading, drive_speed, turn_correction); one
// transaction on res carries four duties and four direction codes. A command
// equal to the last accepted one gives no result. Wheel mounting angles sit
// in four APB registers at byte addresses 0, 4, 8, 12 (reset 45/135/225/315).
// Front stage: a command enters the two-entry job queue whenever it has room.
// Back stage: up to eight serial divisions on one shared divider; it takes a
// new job only when idle with no result pending; zero speed skips the divisions.
// Reset clears the last command to zero and empties the queue.
// When the receiver stalls the result holds; the queue fills to two jobs,
// then cmd.ready drops.
module omni_wheel_drive_mixer (
  input  logic clk_i,
  input  logic rst_ni,
  owdm_cmd_if.sink cmd,
  owdm_res_if.source res,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import owdm_pkg::*;
  logic [3:0][8:0] ang_q;
  logic jv, jr;
  job_t job;

  assign pready = 1'b1;
  assign prdata = {23'b0, ang_q[paddr[3:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= {9'd315, 9'd225, 9'd135, 9'd45};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegW0: ang_q[0] <= pwdata[8:0];
        RegW1: ang_q[1] <= pwdata[8:0];
        RegW2: ang_q[2] <= pwdata[8:0];
        RegW3: ang_q[3] <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  owdm_front u_front (.clk_i, .rst_ni, .cmd, .ang_i(ang_q), .job_valid_o(jv), .job_o(job),
    .job_ready_i(jr));
  owdm_back u_back (.clk_i, .rst_ni, .job_valid_i(jv), .job_i(job), .job_ready_o(jr), .res);
endmodule

// File: rtl/owdm_checker.sv
// owdm_checker: port-level assertions for omni_wheel_drive_mixer, bound in.
// Depends on the top level's ports only.
module owdm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input logic [7:0] d0,
  input logic [1:0] r0,
  input logic pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid) else $error("res dropped");
  a_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && r0 == 2'd0 |-> d0 == 8'd0) else $error("brake duty");
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> r0 != 2'd3) else $error("bad dir");
  a_rdy: assert property (@(posedge clk_i) pready) else $error("pready low");
endmodule

bind omni_wheel_drive_mixer owdm_checker u_chk (.clk_i, .rst_ni, .res_valid(res.valid),
  .res_ready(res.ready), .d0(res.data.wheel0_duty), .r0(res.data.wheel0_dir), .pready);
